### hdl/msp_exu_pkg.sv
// msp_exu_pkg: shared types and constants for the 16-bit execute unit
// command and response item structs, flag masks, format and opcode codes
// no dependencies
`default_nettype none

package msp_exu_pkg;

	// command item: instruction plus already fetched operands
	typedef struct packed {
		logic [15:0] instr_word;
		logic [15:0] src_value;
		logic [15:0] dst_value;
		logic [8:0]  status_in;
		logic [15:0] pc_next;
	} exu_cmd_t;

	// response item
	typedef struct packed {
		logic [15:0] result_value;
		logic [8:0]  status_out;
		logic        write_back;
		logic        branch_taken;
		logic [15:0] branch_target;
		logic        illegal;
	} exu_rsp_t;

	// pending flag update: bits to set, bits to clear (clear wins)
	typedef struct packed {
		logic [8:0] set_m;
		logic [8:0] clr_m;
	} flag_upd_t;

	// status flag masks
	localparam logic [8:0] FLAG_C = 9'h001;
	localparam logic [8:0] FLAG_Z = 9'h002;
	localparam logic [8:0] FLAG_N = 9'h004;
	localparam logic [8:0] FLAG_V = 9'h100;

	// instruction formats, from bits 15..13
	localparam logic [2:0] FMT_SINGLE = 3'b000;
	localparam logic [2:0] FMT_JUMP   = 3'b001;

	// single-operand marker in bits 12..10, and the words that run as rrc anyway
	localparam logic [2:0]  SINGLE_ID  = 3'b100;
	localparam logic [15:0] RRC_ALIAS0 = 16'h0000;
	localparam logic [15:0] RRC_ALIAS1 = 16'h0003;

	// register numbers with special meaning
	localparam logic [3:0] REG_SR = 4'd2;
	localparam logic [3:0] REG_CG = 4'd3;

	// single-operand groups, bits 9..7
	localparam logic [2:0] SG_RRC  = 3'd0;
	localparam logic [2:0] SG_SWPB = 3'd1;
	localparam logic [2:0] SG_RRA  = 3'd2;
	localparam logic [2:0] SG_SXT  = 3'd3;
	localparam logic [2:0] SG_PUSH = 3'd4;
	localparam logic [2:0] SG_CALL = 3'd5;

	// double-operand opcodes, bits 15..12
	localparam logic [3:0] OP_MOV  = 4'h4;
	localparam logic [3:0] OP_ADD  = 4'h5;
	localparam logic [3:0] OP_ADDC = 4'h6;
	localparam logic [3:0] OP_SUB  = 4'h8;
	localparam logic [3:0] OP_CMP  = 4'h9;
	localparam logic [3:0] OP_DADD = 4'hA;
	localparam logic [3:0] OP_BIT  = 4'hB;
	localparam logic [3:0] OP_BIC  = 4'hC;
	localparam logic [3:0] OP_BIS  = 4'hD;
	localparam logic [3:0] OP_XOR  = 4'hE;
	localparam logic [3:0] OP_AND  = 4'hF;

	// jump conditions, bits 12..10
	localparam logic [2:0] JC_NE  = 3'd0;
	localparam logic [2:0] JC_EQ  = 3'd1;
	localparam logic [2:0] JC_NC  = 3'd2;
	localparam logic [2:0] JC_C   = 3'd3;
	localparam logic [2:0] JC_GE  = 3'd5;
	localparam logic [2:0] JC_L   = 3'd6;
	localparam logic [2:0] JC_JMP = 3'd7;

endpackage

`default_nettype wire

### hdl/msp_exu_jump.sv
// msp_exu_jump: conditional jump evaluation and target computation
// depends on msp_exu_pkg
`default_nettype none

module msp_exu_jump (
	input  msp_exu_pkg::exu_cmd_t cmd,
	output msp_exu_pkg::exu_rsp_t rsp
);
	import msp_exu_pkg::*;

	logic [2:0]  cnd;
	logic [15:0] offset;
	logic [15:0] target;
	logic        taken;
	logic        ill;
	logic        flag_n;
	logic        flag_v;

	// doubled, sign-extended 10-bit offset
	assign cnd    = cmd.instr_word[12:10];
	assign offset = {{5{cmd.instr_word[9]}}, cmd.instr_word[9:0], 1'b0};
	assign target = cmd.pc_next + offset;
	assign flag_n = |(cmd.status_in & FLAG_N);
	assign flag_v = |(cmd.status_in & FLAG_V);

	// condition decode
	always_comb begin
		taken = 1'b0;
		ill   = 1'b0;
		case (cnd)
			JC_NE:   taken = ~|(cmd.status_in & FLAG_Z);
			JC_EQ:   taken = |(cmd.status_in & FLAG_Z);
			JC_NC:   taken = ~|(cmd.status_in & FLAG_C);
			JC_C:    taken = |(cmd.status_in & FLAG_C);
			JC_GE:   taken = (flag_n == flag_v);
			JC_L:    taken = (flag_n != flag_v);
			JC_JMP:  taken = 1'b1;
			default: ill = 1'b1;
		endcase
	end

	// response; status passes through untouched
	always_comb begin
		rsp.result_value  = '0;
		rsp.status_out    = cmd.status_in;
		rsp.write_back    = 1'b0;
		rsp.branch_taken  = taken;
		rsp.branch_target = ill ? '0 : target;
		rsp.illegal       = ill;
	end

endmodule

`default_nettype wire

### hdl/msp_exu_alu.sv
// msp_exu_alu: single- and double-operand ALU with flag update
// depends on msp_exu_pkg
`default_nettype none

module msp_exu_alu (
	input  msp_exu_pkg::exu_cmd_t cmd,
	output msp_exu_pkg::exu_rsp_t rsp
);
	import msp_exu_pkg::*;

	// add/sub flags: N only in word mode, V always cleared
	function automatic flag_upd_t arith_flags(input logic [16:0] r, input logic bw);
		flag_upd_t f;
		logic      zero;
		logic      carry;
		f     = '0;
		zero  = bw ? (r[7:0] == 8'h00) : (r[15:0] == 16'h0000);
		carry = bw ? r[8] : r[16];
		if (!bw && r[15]) f.set_m = f.set_m | FLAG_N;
		else              f.clr_m = f.clr_m | FLAG_N;
		f.clr_m = f.clr_m | FLAG_V;
		if (zero)  f.set_m = f.set_m | FLAG_Z;
		else       f.clr_m = f.clr_m | FLAG_Z;
		if (carry) f.set_m = f.set_m | FLAG_C;
		else       f.clr_m = f.clr_m | FLAG_C;
		return f;
	endfunction

	// logic-op flags: C is the inverse of Z
	function automatic flag_upd_t logic_flags(input logic [15:0] r);
		flag_upd_t f;
		f       = '0;
		f.clr_m = FLAG_V;
		if (r[15]) f.set_m = f.set_m | FLAG_N;
		else       f.clr_m = f.clr_m | FLAG_N;
		if (r == 16'h0000) begin
			f.set_m = f.set_m | FLAG_Z;
			f.clr_m = f.clr_m | FLAG_C;
		end else begin
			f.clr_m = f.clr_m | FLAG_Z;
			f.set_m = f.set_m | FLAG_C;
		end
		return f;
	endfunction

	logic [15:0] w;
	logic [15:0] s;
	logic [15:0] d;
	logic        bw;
	logic        cst;
	logic        carry_in;
	logic [15:0] v;
	logic [15:0] a;
	logic [15:0] b;
	logic [16:0] sum;
	logic [16:0] res;
	logic [4:0]  p;
	logic        dcarry;
	logic        setn;
	logic [15:0] dres;
	logic        wb;
	logic        ill;
	flag_upd_t   upd;

	assign w        = cmd.instr_word;
	assign s        = cmd.src_value;
	assign d        = cmd.dst_value;
	assign bw       = w[6];
	assign cst      = (w[3:0] == REG_CG) || ((w[3:0] == REG_SR) && w[5]);
	assign carry_in = |(cmd.status_in & FLAG_C);

	// decimal add, one nibble per digit, two digits in byte mode
	always_comb begin
		dcarry = 1'b0;
		setn   = 1'b0;
		dres   = '0;
		p      = '0;
		for (int i = 0; i < 4; i++) begin
			if (i < 2 || !bw) begin
				p = {1'b0, s[4*i +: 4]} + {1'b0, d[4*i +: 4]} + {4'b0000, dcarry};
				setn = p[3];
				if (p >= 5'd10) begin
					p = p - 5'd10;
					dcarry = 1'b1;
				end else begin
					dcarry = 1'b0;
				end
				dres[4*i +: 4] = p[3:0];
			end
		end
	end

	// operation decode and execute
	always_comb begin
		res = '0;
		upd = '0;
		wb  = 1'b0;
		ill = 1'b0;
		v   = bw ? {8'h00, s[7:0]} : s;
		a   = '0;
		b   = '0;
		sum = '0;
		if (w[15:13] == FMT_SINGLE) begin
			if (w[12:10] != SINGLE_ID && w != RRC_ALIAS0 && w != RRC_ALIAS1)
				ill = 1'b1;
			case (w[9:7])
				SG_RRC: begin
					res = {2'b00, v[15:1]};
					if (carry_in) begin
						if (bw) res[7] = 1'b1;
						else    res[15] = 1'b1;
					end
					if (v[0]) upd.set_m = upd.set_m | FLAG_C;
					else      upd.clr_m = upd.clr_m | FLAG_C;
					if (res[15]) upd.set_m = upd.set_m | FLAG_N;
					if (res != '0) upd.clr_m = upd.clr_m | FLAG_Z;
					wb = !cst;
				end
				SG_SWPB: begin
					res = {1'b0, s[7:0], s[15:8]};
					wb  = !cst;
				end
				SG_RRA: begin
					res = {2'b00, v[15:1]};
					if (bw) res[7]  = v[7];
					else    res[15] = v[15];
					upd.clr_m = upd.clr_m | FLAG_Z;
					if (res[15]) upd.set_m = upd.set_m | FLAG_N;
					wb = !cst;
				end
				SG_SXT: begin
					res = {1'b0, {8{s[7]}}, s[7:0]};
					upd = logic_flags(res[15:0]);
					wb  = !cst;
				end
				SG_PUSH, SG_CALL: begin
					res = {1'b0, s};
					wb  = 1'b1;
				end
				default: ill = 1'b1;
			endcase
		end else if (w[3:0] == REG_CG) begin
			// write to the constant register: nop
			res = '0;
		end else begin
			wb = 1'b1;
			case (w[15:12])
				OP_MOV: res = {1'b0, s};
				OP_ADD, OP_ADDC: begin
					a   = bw ? {8'h00, s[7:0]} : s;
					b   = bw ? {8'h00, d[7:0]} : d;
					sum = {1'b0, a} + {1'b0, b}
						+ {16'h0000, (w[15:12] == OP_ADDC) && carry_in};
					res = sum;
					upd = arith_flags(sum, bw);
				end
				OP_SUB, OP_CMP: begin
					a   = bw ? {8'h00, ~s[7:0]} : ~s;
					b   = bw ? {8'h00, d[7:0]} : d;
					sum = {1'b0, a} + {1'b0, b} + 17'd1;
					res = sum;
					upd = arith_flags(sum, bw);
					if (w[15:12] == OP_CMP) wb = 1'b0;
				end
				OP_DADD: begin
					res = {1'b0, dres};
					if (setn) upd.set_m = upd.set_m | FLAG_N;
					if (dcarry) upd.set_m = upd.set_m | FLAG_C;
					else        upd.clr_m = upd.clr_m | FLAG_C;
				end
				OP_BIC: res = {1'b0, d & ~s};
				OP_BIS: res = {1'b0, d | s};
				OP_XOR: begin
					res = {1'b0, d ^ s};
					if (bw) res[15:8] = 8'h00;
					upd = logic_flags(res[15:0]);
				end
				OP_BIT, OP_AND: begin
					res = {1'b0, d & s};
					if (bw) res[15:8] = 8'h00;
					upd = logic_flags(res[15:0]);
					if (w[15:12] == OP_BIT) wb = 1'b0;
				end
				default: ill = 1'b1;
			endcase
		end
		// an illegal word leaves everything untouched
		if (ill) begin
			res = '0;
			upd = '0;
			wb  = 1'b0;
		end
	end

	// response; byte results zero-extended
	always_comb begin
		rsp.result_value  = bw ? {8'h00, res[7:0]} : res[15:0];
		rsp.status_out    = (cmd.status_in | upd.set_m) & ~upd.clr_m;
		rsp.write_back    = wb;
		rsp.branch_taken  = 1'b0;
		rsp.branch_target = '0;
		rsp.illegal       = ill;
	end

endmodule

`default_nettype wire

### hdl/msp430_execute_alu.sv
// msp430_execute_alu: execute stage, one instruction item per clock
// an accepted item goes through the input register and the result register, then is shown on rsp with done
// throughput: one item per cycle; busy is always low, the result register frees every cycle
// the receiver cannot stall: each result is shown for exactly one cycle
// reset clears both valid flags; payload registers are not reset
// depends on msp_exu_pkg, msp_exu_alu, msp_exu_jump
`default_nettype none

module msp430_execute_alu (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  msp_exu_pkg::exu_cmd_t cmd,
	output logic                  done,
	output msp_exu_pkg::exu_rsp_t rsp
);
	import msp_exu_pkg::*;

	logic     valid_s1;
	exu_cmd_t cmd_s1;
	logic     valid_s2;
	exu_rsp_t rsp_s2;
	exu_rsp_t alu_rsp;
	exu_rsp_t jmp_rsp;
	exu_rsp_t exe_rsp;

	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	// execute units
	msp_exu_alu u_alu (
		.cmd (cmd_s1),
		.rsp (alu_rsp)
	);

	msp_exu_jump u_jump (
		.cmd (cmd_s1),
		.rsp (jmp_rsp)
	);

	assign exe_rsp = (cmd_s1.instr_word[15:13] == FMT_JUMP) ? jmp_rsp : alu_rsp;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_s2 <= exe_rsp;
		end
	end

	assign done = valid_s2;
	assign rsp  = rsp_s2;

	// checks
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> valid_s1)
		else $error("accepted item did not reach the input register");

	a_s1_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("item in the input register produced no result");

	a_illegal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.illegal |-> !rsp.write_back && !rsp.branch_taken
			&& rsp.result_value == 16'h0000 && rsp.branch_target == 16'h0000)
		else $error("illegal item has side effects");

	a_branch_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.branch_taken |-> !rsp.write_back)
		else $error("taken branch also writes back");

	a_status_unused_bits: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.status_out[7:3] == $past(cmd_s1.status_in[7:3]))
		else $error("status bits 7..3 changed");

endmodule

`default_nettype wire

### sim/tb_msp430_execute_alu.sv
`timescale 1ns / 100ps
// tb_msp430_execute_alu: self-checking bench for the execute stage, directed cases then random items
// predicts every response from the command in plain systemverilog and compares field by field
// depends on msp_exu_pkg and msp430_execute_alu

module tb_msp430_execute_alu;
	import msp_exu_pkg::*;

	// codes the package leaves out, all decoded as illegal
	localparam logic [3:0] OP_SUBC  = 4'h7;
	localparam logic [2:0] SG_BAD   = 3'd6;
	localparam int         LATENCY  = 2;
	localparam int         QUIET_LIMIT = 1000;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	exu_cmd_t cmd;
	logic     done;
	exu_rsp_t rsp;

	exu_rsp_t    predicted_rsp_q[$];
	int unsigned n_items;
	int unsigned n_results;
	int unsigned n_taken;
	int unsigned n_illegal;
	int unsigned n_errors;
	int unsigned quiet_cycles;

	msp430_execute_alu dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// flag update after add or subtract
	function automatic flag_upd_t arith_flag_upd(logic [31:0] sum, bit byte_mode);
		flag_upd_t u;
		logic [15:0] low;
		u = '0;
		low = byte_mode ? {8'h00, sum[7:0]} : sum[15:0];
		if (!byte_mode && sum[15]) u.set_m |= FLAG_N; else u.clr_m |= FLAG_N;
		u.clr_m |= FLAG_V;
		if (low == 16'h0000) u.set_m |= FLAG_Z; else u.clr_m |= FLAG_Z;
		if (byte_mode ? sum[8] : sum[16]) u.set_m |= FLAG_C; else u.clr_m |= FLAG_C;
		return u;
	endfunction

	// flag update after logic ops and sxt: c is the inverse of z
	function automatic flag_upd_t logic_flag_upd(logic [15:0] val);
		flag_upd_t u;
		u = '0;
		u.clr_m |= FLAG_V;
		if (val[15]) u.set_m |= FLAG_N; else u.clr_m |= FLAG_N;
		if (val == 16'h0000) begin
			u.set_m |= FLAG_Z;
			u.clr_m |= FLAG_C;
		end else begin
			u.clr_m |= FLAG_Z;
			u.set_m |= FLAG_C;
		end
		return u;
	endfunction

	// expected response for one instruction item
	function automatic exu_rsp_t execute_instr(exu_cmd_t c);
		logic [15:0] w, a, b, v, off;
		logic [31:0] res;
		logic [8:0]  st;
		logic [4:0]  digit;
		logic        dcarry, dneg;
		flag_upd_t   f;
		bit          bw, wb, bt, ill, cst;
		int          lim;
		exu_rsp_t    r;
		w = c.instr_word;
		st = c.status_in;
		bw = w[6];
		res = '0;
		f = '0;
		wb = 1'b0;
		bt = 1'b0;
		ill = 1'b0;
		r = '0;
		if (w[15:13] == FMT_JUMP) begin
			// conditional jumps, offset in words
			off = {{5{w[9]}}, w[9:0], 1'b0};
			r.branch_target = c.pc_next + off;
			case (w[12:10])
				JC_NE:  bt = (st & FLAG_Z) == 9'h0;
				JC_EQ:  bt = (st & FLAG_Z) != 9'h0;
				JC_NC:  bt = (st & FLAG_C) == 9'h0;
				JC_C:   bt = (st & FLAG_C) != 9'h0;
				JC_GE:  bt = ((st & FLAG_N) != 9'h0) == ((st & FLAG_V) != 9'h0);
				JC_L:   bt = ((st & FLAG_N) != 9'h0) != ((st & FLAG_V) != 9'h0);
				JC_JMP: bt = 1'b1;
				default: ill = 1'b1;
			endcase
		end else if (w[15:13] == FMT_SINGLE) begin
			// single-operand ops; constant sources leave nothing to write, but for push and call
			cst = (w[3:0] == REG_CG) || (w[3:0] == REG_SR && w[5]);
			v = c.src_value;
			if (w[12:10] != SINGLE_ID && w != RRC_ALIAS0 && w != RRC_ALIAS1)
				ill = 1'b1;
			case (w[9:7])
				SG_RRC: begin
					if (bw) v = v & 16'h00ff;
					res = v >> 1;
					if ((st & FLAG_C) != 9'h0) res |= bw ? 32'h0080 : 32'h8000;
					if (v[0]) f.set_m |= FLAG_C; else f.clr_m |= FLAG_C;
					if (res[15]) f.set_m |= FLAG_N;
					if (res != 0) f.clr_m |= FLAG_Z;
					wb = !cst;
				end
				SG_SWPB: begin
					res = {v[7:0], v[15:8]};
					wb = !cst;
				end
				SG_RRA: begin
					if (bw) v = v & 16'h00ff;
					res = v >> 1;
					if (bw ? v[7] : v[15]) res |= bw ? 32'h0080 : 32'h8000;
					f.clr_m |= FLAG_Z;
					if (res[15]) f.set_m |= FLAG_N;
					wb = !cst;
				end
				SG_SXT: begin
					res = v[7] ? (v | 16'hff00) : (v & 16'h00ff);
					f = logic_flag_upd(res[15:0]);
					wb = !cst;
				end
				SG_PUSH, SG_CALL: begin
					res = v;
					wb = 1'b1;
				end
				default: ill = 1'b1;
			endcase
		end else if (w[3:0] == REG_CG) begin
			// write to the constant register does nothing
			res = '0;
		end else begin
			// double-operand ops
			a = c.src_value;
			b = c.dst_value;
			wb = 1'b1;
			case (w[15:12])
				OP_MOV: res = a;
				OP_ADD, OP_ADDC: begin
					if (bw) begin
						a = a & 16'h00ff;
						b = b & 16'h00ff;
					end
					res = a + b + ((w[15:12] == OP_ADDC && (st & FLAG_C) != 9'h0) ? 1 : 0);
					f = arith_flag_upd(res, bw);
				end
				OP_SUB, OP_CMP: begin
					a = ~a;
					if (bw) begin
						a = a & 16'h00ff;
						b = b & 16'h00ff;
					end
					res = a + b + 1;
					f = arith_flag_upd(res, bw);
					if (w[15:12] == OP_CMP) wb = 1'b0;
				end
				OP_DADD: begin
					dcarry = 1'b0;
					dneg = 1'b0;
					lim = bw ? 8 : 16;
					for (int i = 0; i < lim; i += 4) begin
						digit = a[i+:4] + b[i+:4] + dcarry;
						dneg = digit[3];
						if (digit >= 5'd10) begin
							digit = digit - 5'd10;
							dcarry = 1'b1;
						end else begin
							dcarry = 1'b0;
						end
						res[i+:4] = digit[3:0];
					end
					if (dneg) f.set_m |= FLAG_N;
					if (dcarry) f.set_m |= FLAG_C; else f.clr_m |= FLAG_C;
				end
				OP_BIC: res = b & ~a;
				OP_BIS: res = b | a;
				OP_XOR: begin
					res = b ^ a;
					if (bw) res &= 32'h00ff;
					f = logic_flag_upd(res[15:0]);
				end
				OP_BIT, OP_AND: begin
					res = b & a;
					if (bw) res &= 32'h00ff;
					f = logic_flag_upd(res[15:0]);
					if (w[15:12] == OP_BIT) wb = 1'b0;
				end
				default: ill = 1'b1;
			endcase
		end
		// illegal words leave everything untouched
		if (ill) begin
			res = '0;
			f = '0;
			wb = 1'b0;
			bt = 1'b0;
			r.branch_target = '0;
		end
		st = (st | f.set_m) & ~f.clr_m;
		if (bw && w[15:13] != FMT_JUMP) res &= 32'h00ff;
		r.result_value = res[15:0];
		r.status_out = st;
		r.write_back = wb;
		r.branch_taken = bt;
		r.illegal = ill;
		return r;
	endfunction

	function automatic exu_cmd_t mk_cmd(logic [15:0] w, logic [15:0] s, logic [15:0] d,
			logic [8:0] st, logic [15:0] pc);
		exu_cmd_t c;
		c.instr_word = w;
		c.src_value = s;
		c.dst_value = d;
		c.status_in = st;
		c.pc_next = pc;
		return c;
	endfunction

	function automatic logic [15:0] dbl_word(logic [3:0] op, logic [3:0] sreg, logic [3:0] dreg,
			bit bw);
		return {op, sreg, 1'b0, bw, 2'b00, dreg};
	endfunction

	function automatic logic [15:0] single_word(logic [2:0] grp, bit bw, logic [1:0] as_mode,
			logic [3:0] rg);
		return {FMT_SINGLE, SINGLE_ID, grp, bw, as_mode, rg};
	endfunction

	// operand values lean toward the corners
	function automatic logic [15:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h8000;
			3: return 16'h7fff;
			4: return 16'($urandom_range(0, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [3:0] pick_dbl_op();
		case ($urandom_range(0, 10))
			0: return OP_MOV;
			1: return OP_ADD;
			2: return OP_ADDC;
			3: return OP_SUB;
			4: return OP_CMP;
			5: return OP_DADD;
			6: return OP_BIT;
			7: return OP_BIC;
			8: return OP_BIS;
			9: return OP_XOR;
			default: return OP_AND;
		endcase
	endfunction

	// mostly decodable words with random fields, some raw noise
	function automatic exu_cmd_t rand_cmd();
		exu_cmd_t c;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			c.instr_word = {pick_dbl_op(), 12'($urandom)};
		else if (pick < 65)
			c.instr_word = {FMT_SINGLE, SINGLE_ID, 3'($urandom_range(0, 7)), 7'($urandom)};
		else if (pick < 85)
			c.instr_word = {FMT_JUMP, 13'($urandom)};
		else
			c.instr_word = 16'($urandom);
		c.src_value = pick_operand();
		c.dst_value = pick_operand();
		c.status_in = 9'($urandom);
		c.pc_next = 16'($urandom);
		return c;
	endfunction

	// sender gap: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		else if (r < 92) return $urandom_range(1, 3);
		else return $urandom_range(8, 40);
	endfunction

	// present one item until accepted, then idle for gap cycles
	task automatic send_item(exu_cmd_t c, int unsigned gap);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		predicted_rsp_q.push_back(execute_instr(c));
		n_items++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending until every expected response has come back
	task automatic wait_drain();
		start <= 1'b0;
		do @(posedge clk); while (predicted_rsp_q.size() != 0);
	endtask

	task automatic test_double_ops();
		send_item(mk_cmd(dbl_word(OP_MOV, 4'd5, 4'd4, 1'b0), 16'hffff, 16'h1234, 9'h000,
			16'h4400), pick_gap());
		send_item(mk_cmd(dbl_word(OP_ADD, 4'd5, 4'd4, 1'b0), 16'hffff, 16'h0001, 9'h100,
			16'h4402), pick_gap());
		send_item(mk_cmd(dbl_word(OP_ADDC, 4'd5, 4'd4, 1'b1), 16'h127f, 16'hab80, 9'h001,
			16'h4404), pick_gap());
		send_item(mk_cmd(dbl_word(OP_SUB, 4'd5, 4'd4, 1'b0), 16'h0001, 16'h0000, 9'h1ff,
			16'h4406), pick_gap());
		send_item(mk_cmd(dbl_word(OP_CMP, 4'd5, 4'd4, 1'b0), 16'h8000, 16'h8000, 9'h000,
			16'h4408), pick_gap());
		send_item(mk_cmd(dbl_word(OP_DADD, 4'd5, 4'd4, 1'b0), 16'h0999, 16'h0001, 9'h000,
			16'h440a), pick_gap());
		send_item(mk_cmd(dbl_word(OP_DADD, 4'd5, 4'd4, 1'b1), 16'h0099, 16'h0001, 9'h1ff,
			16'h440c), pick_gap());
		send_item(mk_cmd(dbl_word(OP_BIT, 4'd5, 4'd4, 1'b0), 16'h8000, 16'h8000, 9'h000,
			16'h440e), pick_gap());
		send_item(mk_cmd(dbl_word(OP_BIC, 4'd5, 4'd4, 1'b0), 16'hffff, 16'hffff, 9'h1ff,
			16'h4410), pick_gap());
		send_item(mk_cmd(dbl_word(OP_BIS, 4'd5, 4'd4, 1'b1), 16'h00ff, 16'hff00, 9'h000,
			16'h4412), pick_gap());
		send_item(mk_cmd(dbl_word(OP_XOR, 4'd5, 4'd4, 1'b1), 16'h00ff, 16'h00ff, 9'h107,
			16'h4414), pick_gap());
		send_item(mk_cmd(dbl_word(OP_AND, 4'd5, 4'd4, 1'b0), 16'h0000, 16'hffff, 9'h001,
			16'h4416), pick_gap());
		// constant register destination, then the missing subc opcode
		send_item(mk_cmd(dbl_word(OP_ADD, 4'd5, REG_CG, 1'b0), 16'hffff, 16'h0001, 9'h0aa,
			16'h4418), pick_gap());
		send_item(mk_cmd(dbl_word(OP_SUBC, 4'd5, 4'd4, 1'b0), 16'h1111, 16'h2222, 9'h155,
			16'h441a), pick_gap());
	endtask

	task automatic test_single_ops();
		// every defined group and the bad group 6, byte mode on odd groups, carry in set
		for (int g = 0; g <= int'(SG_BAD); g++)
			send_item(mk_cmd(single_word(3'(g), g % 2 == 1, 2'b00, 4'd6), 16'h8081, 16'h0000,
				9'h1ff, 16'hfffe), pick_gap());
		// constant source: flags move but nothing is written
		send_item(mk_cmd(single_word(SG_RRA, 1'b0, 2'b10, REG_SR), 16'h0004, 16'h0000, 9'h002,
			16'h0000), pick_gap());
		// the two words that run as rrc, and a word with a bad single-operand marker
		send_item(mk_cmd(RRC_ALIAS0, 16'h0001, 16'h0000, 9'h001, 16'h0100), pick_gap());
		send_item(mk_cmd(RRC_ALIAS1, 16'hfffe, 16'h0000, 9'h000, 16'h0102), pick_gap());
		send_item(mk_cmd(single_word(SG_SWPB, 1'b0, 2'b00, 4'd7) ^ 16'h1000, 16'h1234, 16'h0000,
			9'h000, 16'h0104), pick_gap());
	endtask

	task automatic test_jumps();
		// each condition, with the most negative and most positive offsets
		for (int cnd = 0; cnd < 8; cnd++)
			send_item(mk_cmd({FMT_JUMP, 3'(cnd), (cnd % 2 == 1) ? 10'h200 : 10'h1ff},
				16'($urandom), 16'($urandom), 9'($urandom), (cnd % 2 == 1) ? 16'h0002 : 16'hfffe),
				pick_gap());
	endtask

	task automatic test_drain_pause();
		for (int round = 0; round < 2; round++) begin
			for (int i = 0; i < 15; i++)
				send_item(rand_cmd(), 0);
			wait_drain();
		end
	endtask

	task automatic test_random_mix(int unsigned count);
		bit steady;
		steady = 1'b0;
		for (int unsigned i = 0; i < count; i++) begin
			// some stretches run with no gaps at all
			if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
			send_item(rand_cmd(), steady ? 0 : pick_gap());
		end
	endtask

	task automatic check_field(string fname, logic [15:0] want_v, logic [15:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want_v, got_v);
			n_errors++;
		end
	endtask

	// response checker
	always @(posedge clk) begin : rsp_check
		exu_rsp_t want;
		if (arst_n && done) begin
			n_results++;
			if (rsp.branch_taken === 1'b1) n_taken++;
			if (rsp.illegal === 1'b1) n_illegal++;
			if (predicted_rsp_q.size() == 0) begin
				$display("%0t: response with no item pending: expected none, actual %h",
					$time, rsp);
				n_errors++;
			end else begin
				want = predicted_rsp_q.pop_front();
				check_field("result_value", want.result_value, rsp.result_value);
				check_field("status_out", 16'(want.status_out), 16'(rsp.status_out));
				check_field("write_back", 16'(want.write_back), 16'(rsp.write_back));
				check_field("branch_taken", 16'(want.branch_taken), 16'(rsp.branch_taken));
				check_field("branch_target", want.branch_target, rsp.branch_target);
				check_field("illegal", 16'(want.illegal), 16'(rsp.illegal));
			end
		end
	end

	// watchdog on cycles where neither side moves an item
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// test sequence
	initial begin
		n_items = 0;
		n_results = 0;
		n_taken = 0;
		n_illegal = 0;
		n_errors = 0;
		quiet_cycles = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_double_ops();
		test_single_ops();
		test_jumps();
		test_drain_pause();
		test_random_mix(990);

		wait_drain();
		repeat (LATENCY + 4) @(posedge clk);
		$display("ran %0d instruction items, %0d responses checked", n_items, n_results);
		$display("covered all op groups, byte mode, %0d taken jumps, %0d illegal words",
			n_taken, n_illegal);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
